// ===== design/hste_pkg.sv =====
// Shared codes, state types and control structs of the transition engine.
`timescale 1ns / 1ps
`default_nettype none

package hste_pkg;

    // Command codes carried in the input selector
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_EVENT   = 3'd1;
    localparam logic [2:0] OP_REQUEST = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_ENABLE  = 3'd4;

    // Action kinds
    localparam logic [2:0] KIND_STATUS  = 3'd0;
    localparam logic [2:0] KIND_HANDLER = 3'd1;
    localparam logic [2:0] KIND_EXIT    = 3'd2;
    localparam logic [2:0] KIND_ENTRY   = 3'd3;
    localparam logic [2:0] KIND_CONT    = 3'd4;

    // Run status codes
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_DISABLED    = 3'd1;
    localparam logic [2:0] STS_NOT_STARTED = 3'd2;
    localparam logic [2:0] STS_BAD_STATE   = 3'd3;
    localparam logic [2:0] STS_QUEUE_FULL  = 3'd4;
    localparam logic [2:0] STS_NO_ANCESTOR = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_PARENT    = 3'd0;
    localparam logic [2:0] REG_STATE_CNT = 3'd1;
    localparam logic [2:0] REG_RULE_CNT  = 3'd2;
    localparam logic [2:0] REG_RULE_EVT  = 3'd3;
    localparam logic [2:0] REG_RULE_FROM = 3'd4;
    localparam logic [2:0] REG_RULE_TO   = 3'd5;

    localparam logic [3:0] ANY_STATE = 4'd8;
    // Action words per run, the status word not counted
    localparam logic [5:0] ACT_LIMIT = 6'd39;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WALK, S_HANDLER, S_RULE, S_DRAIN,
        S_LCA, S_EXIT, S_ENTER, S_CONT, S_STATUS
    } fsm_t;

    typedef enum logic [1:0] {PH_START, PH_HANDLE, PH_TRANS} phase_t;

    typedef enum logic [1:0] {SRC_HANDLER, SRC_EXIT, SRC_ENTER, SRC_CONT} emit_src_t;

    typedef struct packed {
        logic       accept;
        logic       emit;
        emit_src_t  emit_src;
        logic       emit_status;
        logic       note;
        logic [2:0] note_code;
        logic       set_enable;
        logic       load_enable;
        logic       walk_init;
        logic       walk_from_q;
        logic       walk_step;
        logic       k_step;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_load_enter;
        logic       pop;
        logic       push;
        logic       push_rule;
        logic       commit;
        logic       set_started;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       arg_ok;
        logic       enabled;
        logic       started;
        logic       walk_done;
        logic       lca_more;
        logic       k_zero;
        logic       exit_none;
        logic       enter_none;
        logic       handler_stop;
        logic       exit_last;
        logic       enter_last;
        logic       q_empty;
        logic       pop_bad;
        logic       pop_same;
        logic       out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/hste_dp.sv =====
// Datapath: configuration, machine state, pending queue, ancestor walkers, output word.
`timescale 1ns / 1ps
`default_nettype none

module hste_dp import hste_pkg::*; #(
    parameter int NUM_STATES  = 8,
    parameter int MAX_DEPTH   = 4,
    parameter int QUEUE_DEPTH = 4,
    parameter int NUM_RULES   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [2:0]  in_op,
    input  wire logic [2:0]  in_arg,
    input  wire logic [7:0]  in_event,
    input  wire logic [7:0]  in_hmask,
    input  wire logic [7:0]  in_gmask,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [2:0]       out_kind,
    output logic [2:0]       out_state,
    output logic [7:0]       out_event,
    output logic [2:0]       out_status,
    output logic             out_last
);

    localparam int LW   = $clog2(MAX_DEPTH + 1);
    localparam int IDXW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CAP  = (NUM_STATES > 8) ? 8 : NUM_STATES;

    // configuration
    logic [31:0] parent_reg;
    logic [3:0]  scount_reg;
    logic [3:0]  rcount_reg;
    logic [63:0] revt_reg;
    logic [31:0] rfrom_reg;
    logic [23:0] rto_reg;

    // machine state
    logic [2:0]    cur_reg;
    logic          started_reg;
    logic          enabled_reg;
    logic [QW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [10:0]   q_mem [QUEUE_DEPTH];
    logic [2:0]    run_status_reg;
    logic [5:0]    act_cnt_reg;

    // item and working registers
    logic [2:0] op_reg, arg_reg;
    logic [7:0] ev_reg, hmask_reg, gmask_reg;
    logic [2:0] tgt_reg;
    logic [7:0] tev_reg;
    logic [2:0] a_buf [MAX_DEPTH];
    logic [2:0] b_buf [MAX_DEPTH];
    logic [2:0] a_s_reg, b_s_reg;
    logic [LW-1:0] a_len_reg, b_len_reg, k_reg, idx_reg;
    logic       a_done_reg, b_done_reg;

    // output word
    logic       out_valid_reg, out_last_reg;
    logic [2:0] out_kind_reg, out_state_reg, out_status_reg;
    logic [7:0] out_event_reg;

    logic [3:0]  eff_cnt, rc;
    logic        arg_ok;
    logic [10:0] q_rd;
    logic [2:0]  init_b;
    logic [3:0]  a_par, b_par;
    logic        a_stop, b_stop;
    logic [LW-1:0] ia, ib, idm1;
    logic [2:0]  a_at_idx;
    logic        rule_hit;
    logic [2:0]  rule_tgt;
    logic [2:0]  push_tgt, push_err, note_code;
    logic        push_go, push_ok, q_full;
    logic [SW-1:0] wsum, wa;
    logic        out_free, act_room;
    logic [2:0]  emit_kind, emit_state;
    logic [7:0]  emit_event;

    assign eff_cnt = (scount_reg > 4'(CAP)) ? 4'(CAP) : scount_reg;
    assign rc      = (rcount_reg > 4'(NUM_RULES)) ? 4'(NUM_RULES) : rcount_reg;
    assign arg_ok  = {1'b0, arg_reg} < eff_cnt;
    assign q_rd    = q_mem[head_reg];
    assign init_b  = cmd.walk_from_q ? q_rd[10:8] : arg_reg;

    // one step up each ancestor chain
    assign a_par  = parent_reg[{a_s_reg, 2'b00} +: 4];
    assign b_par  = parent_reg[{b_s_reg, 2'b00} +: 4];
    assign a_stop = (a_par >= eff_cnt) || (a_len_reg == LW'(MAX_DEPTH - 1));
    assign b_stop = (b_par >= eff_cnt) || (b_len_reg == LW'(MAX_DEPTH - 1));

    // common-ancestor compare, from the root end
    assign ia   = a_len_reg - LW'(1) - k_reg;
    assign ib   = b_len_reg - LW'(1) - k_reg;
    assign idm1 = idx_reg - LW'(1);
    assign a_at_idx = a_buf[idx_reg[IDXW-1:0]];

    always_comb begin
        rule_hit = 1'b0;
        rule_tgt = 3'd0;
        for (int i = NUM_RULES - 1; i >= 0; i--) begin
            if ((4'(i) < rc) && (revt_reg[8*i +: 8] == ev_reg) &&
                ((rfrom_reg[4*i +: 4] == ANY_STATE) ||
                 (rfrom_reg[4*i +: 4] == {1'b0, cur_reg})) &&
                gmask_reg[i]) begin
                rule_hit = 1'b1;
                rule_tgt = rto_reg[3*i +: 3];
            end
        end
    end

    // queue push with its own error notes
    assign q_full   = (count_reg == CW'(QUEUE_DEPTH));
    assign push_tgt = cmd.push_rule ? rule_tgt : arg_reg;
    assign push_go  = cmd.push && (!cmd.push_rule || rule_hit);
    always_comb begin
        push_err = STS_OK;
        push_ok  = 1'b0;
        if (push_go) begin
            if ({1'b0, push_tgt} >= eff_cnt) push_err = STS_BAD_STATE;
            else if (q_full)                 push_err = STS_QUEUE_FULL;
            else                             push_ok  = 1'b1;
        end
    end
    assign wsum = SW'(head_reg) + SW'(count_reg);
    assign wa   = (wsum >= SW'(QUEUE_DEPTH)) ? wsum - SW'(QUEUE_DEPTH) : wsum;
    assign note_code = cmd.note ? cmd.note_code : push_err;

    always_comb begin
        case (cmd.emit_src)
            SRC_HANDLER: begin
                emit_kind = KIND_HANDLER; emit_state = a_at_idx; emit_event = ev_reg;
            end
            SRC_EXIT: begin
                emit_kind = KIND_EXIT; emit_state = a_at_idx; emit_event = tev_reg;
            end
            SRC_ENTER: begin
                emit_kind = KIND_ENTRY; emit_state = b_buf[idm1[IDXW-1:0]];
                emit_event = tev_reg;
            end
            default: begin
                emit_kind = KIND_CONT; emit_state = cur_reg; emit_event = 8'd0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign act_room = act_cnt_reg < ACT_LIMIT;

    always_comb begin
        sts              = '0;
        sts.op           = op_reg;
        sts.arg_ok       = arg_ok;
        sts.enabled      = enabled_reg;
        sts.started      = started_reg;
        sts.walk_done    = a_done_reg && b_done_reg;
        sts.lca_more     = (k_reg < a_len_reg) && (k_reg < b_len_reg) &&
                           (a_buf[ia[IDXW-1:0]] == b_buf[ib[IDXW-1:0]]);
        sts.k_zero       = (k_reg == '0);
        sts.exit_none    = (a_len_reg == k_reg);
        sts.enter_none   = (b_len_reg == k_reg);
        sts.handler_stop = hmask_reg[a_at_idx] || ((idx_reg + LW'(1)) == a_len_reg);
        sts.exit_last    = ((idx_reg + LW'(1)) == (a_len_reg - k_reg));
        sts.enter_last   = (idx_reg == LW'(1));
        sts.q_empty      = (count_reg == '0);
        sts.pop_bad      = ({1'b0, q_rd[10:8]} >= eff_cnt);
        sts.pop_same     = (q_rd[10:8] == cur_reg);
        sts.out_free     = out_free;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parent_reg     <= 32'h8888_8888;
            scount_reg     <= 4'd1;
            rcount_reg     <= 4'd0;
            revt_reg       <= '0;
            rfrom_reg      <= '0;
            rto_reg        <= '0;
            cur_reg        <= 3'd0;
            started_reg    <= 1'b0;
            enabled_reg    <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            run_status_reg <= STS_OK;
            act_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PARENT:    parent_reg <= cfg_data[31:0];
                    REG_STATE_CNT: scount_reg <= cfg_data[3:0];
                    REG_RULE_CNT:  rcount_reg <= cfg_data[3:0];
                    REG_RULE_EVT:  revt_reg   <= cfg_data;
                    REG_RULE_FROM: rfrom_reg  <= cfg_data[31:0];
                    REG_RULE_TO:   rto_reg    <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (cmd.set_enable)  enabled_reg <= 1'b1;
            if (cmd.load_enable) enabled_reg <= arg_reg[0];
            if (cmd.commit)      cur_reg     <= tgt_reg;
            if (cmd.set_started) started_reg <= 1'b1;
            if (cmd.pop) begin
                head_reg  <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
                count_reg <= count_reg - CW'(1);
            end else if (push_ok) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.accept) begin
                run_status_reg <= STS_OK;
                act_cnt_reg    <= '0;
            end else if (run_status_reg == STS_OK) begin
                run_status_reg <= note_code;
            end
            if (cmd.emit_status || (cmd.emit && act_room)) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit && act_room) act_cnt_reg <= act_cnt_reg + 6'd1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= in_op;
            arg_reg   <= in_arg;
            ev_reg    <= in_event;
            hmask_reg <= in_hmask;
            gmask_reg <= in_gmask;
        end
        if (push_ok) q_mem[wa[QW-1:0]] <= {push_tgt, ev_reg};
        if (cmd.walk_init) begin
            a_s_reg    <= cur_reg;
            b_s_reg    <= init_b;
            a_len_reg  <= '0;
            b_len_reg  <= '0;
            a_done_reg <= 1'b0;
            b_done_reg <= 1'b0;
            k_reg      <= '0;
            idx_reg    <= '0;
            tgt_reg    <= init_b;
            tev_reg    <= cmd.walk_from_q ? q_rd[7:0] : ev_reg;
        end else begin
            if (cmd.walk_step) begin
                if (!a_done_reg) begin
                    a_buf[a_len_reg[IDXW-1:0]] <= a_s_reg;
                    a_len_reg <= a_len_reg + LW'(1);
                    if (a_stop) a_done_reg <= 1'b1;
                    else        a_s_reg    <= a_par[2:0];
                end
                if (!b_done_reg) begin
                    b_buf[b_len_reg[IDXW-1:0]] <= b_s_reg;
                    b_len_reg <= b_len_reg + LW'(1);
                    if (b_stop) b_done_reg <= 1'b1;
                    else        b_s_reg    <= b_par[2:0];
                end
            end
            if (cmd.k_step) k_reg <= k_reg + LW'(1);
            if (cmd.idx_load_enter)  idx_reg <= b_len_reg - k_reg;
            else if (cmd.idx_inc)    idx_reg <= idx_reg + LW'(1);
            else if (cmd.idx_dec)    idx_reg <= idm1;
        end
        if (cmd.emit_status) begin
            out_kind_reg   <= KIND_STATUS;
            out_state_reg  <= 3'd0;
            out_event_reg  <= 8'd0;
            out_status_reg <= run_status_reg;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit && act_room) begin
            out_kind_reg   <= emit_kind;
            out_state_reg  <= emit_state;
            out_event_reg  <= emit_event;
            out_status_reg <= STS_OK;
            out_last_reg   <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_state  = out_state_reg;
    assign out_event  = out_event_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("pending count beyond queue depth");
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_kind_reg == KIND_STATUS)
        else $error("final word is not a status word");
    a_action_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> out_status_reg == STS_OK)
        else $error("action word carries a status code");
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> count_reg != '0)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/hste_ctrl.sv =====
// Sequencer: decodes each command word and steps the datapath through its run.
`timescale 1ns / 1ps
`default_nettype none

module hste_ctrl import hste_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    fsm_t   state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_START;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                state_next = S_STATUS;
                unique case (sts.op) inside
                    OP_START: begin
                        if (!sts.arg_ok) begin
                            cmd.note = 1'b1; cmd.note_code = STS_BAD_STATE;
                        end else begin
                            cmd.set_enable = 1'b1;
                            cmd.walk_init  = 1'b1;
                            phase_next     = PH_START;
                            state_next     = S_WALK;
                        end
                    end
                    OP_EVENT, OP_TICK: begin
                        if (!sts.enabled) begin
                            cmd.note = 1'b1; cmd.note_code = STS_DISABLED;
                        end else if (!sts.started) begin
                            cmd.note = 1'b1; cmd.note_code = STS_NOT_STARTED;
                        end else if (sts.op == OP_TICK) begin
                            state_next = S_DRAIN;
                        end else begin
                            cmd.walk_init = 1'b1;
                            phase_next    = PH_HANDLE;
                            state_next    = S_WALK;
                        end
                    end
                    OP_REQUEST: begin
                        if (!sts.enabled) begin
                            cmd.note = 1'b1; cmd.note_code = STS_DISABLED;
                        end else if (!sts.arg_ok) begin
                            cmd.note = 1'b1; cmd.note_code = STS_BAD_STATE;
                        end else if (!sts.started) begin
                            cmd.note = 1'b1; cmd.note_code = STS_NOT_STARTED;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    OP_ENABLE: cmd.load_enable = 1'b1;
                    default: ;
                endcase
            end
            S_WALK: begin
                if (!sts.walk_done) begin
                    cmd.walk_step = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_START: begin
                            cmd.idx_load_enter = 1'b1;
                            state_next = S_ENTER;
                        end
                        PH_HANDLE: state_next = S_HANDLER;
                        default:   state_next = S_LCA;
                    endcase
                end
            end
            S_HANDLER: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_HANDLER;
                    if (sts.handler_stop) state_next = S_RULE;
                    else                  cmd.idx_inc = 1'b1;
                end
            end
            S_RULE: begin
                cmd.push      = 1'b1;
                cmd.push_rule = 1'b1;
                state_next    = S_DRAIN;
            end
            S_DRAIN: begin
                if (sts.q_empty) begin
                    state_next = (sts.op == OP_TICK) ? S_CONT : S_STATUS;
                end else begin
                    cmd.pop         = 1'b1;
                    cmd.walk_init   = 1'b1;
                    cmd.walk_from_q = 1'b1;
                    if (sts.pop_bad) begin
                        cmd.note = 1'b1; cmd.note_code = STS_BAD_STATE;
                    end else if (!sts.pop_same) begin
                        phase_next = PH_TRANS;
                        state_next = S_WALK;
                    end
                end
            end
            S_LCA: begin
                if (sts.lca_more) begin
                    cmd.k_step = 1'b1;
                end else if (sts.k_zero) begin
                    cmd.note = 1'b1; cmd.note_code = STS_NO_ANCESTOR;
                    state_next = S_DRAIN;
                end else if (!sts.exit_none) begin
                    state_next = S_EXIT;
                end else if (sts.enter_none) begin
                    cmd.commit = 1'b1;
                    state_next = S_DRAIN;
                end else begin
                    cmd.idx_load_enter = 1'b1;
                    state_next = S_ENTER;
                end
            end
            S_EXIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_EXIT;
                    if (!sts.exit_last) begin
                        cmd.idx_inc = 1'b1;
                    end else if (sts.enter_none) begin
                        cmd.commit = 1'b1;
                        state_next = S_DRAIN;
                    end else begin
                        cmd.idx_load_enter = 1'b1;
                        state_next = S_ENTER;
                    end
                end
            end
            S_ENTER: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_ENTER;
                    cmd.idx_dec  = 1'b1;
                    if (sts.enter_last) begin
                        cmd.commit = 1'b1;
                        if (phase_reg == PH_START) begin
                            cmd.set_started = 1'b1;
                            state_next = S_STATUS;
                        end else begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_CONT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_CONT;
                    state_next   = S_STATUS;
                end
            end
            S_STATUS: begin
                if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/hierarchical_state_transition_engine_top.sv =====
// Top level of the hierarchical state transition engine.
//
// Input words (s_*) carry one command each: start, event, transition request,
// tick or set enable, with the command code on s_tuser. Each command yields a
// run of action words on m_* (handler calls, exits, entries, continuous action)
// closed by one status word with m_tlast high, which holds the first error of
// the run. Configuration words on cfg_* load the parent table, state and rule
// counts and the rule tables; cfg_ready is always high, write only while idle.
// Timing: one input word is taken at a time. A run steps through accept, decode,
// the ancestor walks, the common-ancestor compare, each emitted action, the rule
// match of an event, each queue entry and the final empty check, and closes with
// the status word.
// A stall on m_tready freezes the sequencer in place; nothing is dropped.
// Reset (aresetn low, synchronous) restores the configuration defaults,
// clears current state, started, enabled and the pending queue.
`timescale 1ns / 1ps
`default_nettype none

module hierarchical_state_transition_engine_top import hste_pkg::*; #(
    parameter int NUM_STATES  = 8,
    parameter int MAX_DEPTH   = 4,
    parameter int QUEUE_DEPTH = 4,
    parameter int NUM_RULES   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // state_arg, event_id, handled_mask, guard_pass
    input  wire logic [2:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // action_state, action_event, status
    output logic [2:0]       m_tuser,   // action_kind
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic [2:0] out_state, out_status;
    logic [7:0] out_event;

    assign cfg_ready = 1'b1;

    hste_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hste_dp #(
        .NUM_STATES  (NUM_STATES),
        .MAX_DEPTH   (MAX_DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_RULES   (NUM_RULES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (s_tuser),
        .in_arg     (s_tdata[2:0]),
        .in_event   (s_tdata[10:3]),
        .in_hmask   (s_tdata[18:11]),
        .in_gmask   (s_tdata[26:19]),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_state  (out_state),
        .out_event  (out_event),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_status, out_event, out_state};

endmodule

`default_nettype wire

// ===== bench/tb_hierarchical_state_transition_engine_top.sv =====
// Self-checking bench for the hierarchical state transition engine top level.
`timescale 1ns / 1ps

module tb_hierarchical_state_transition_engine_top;
    import hste_pkg::*;

    localparam int NST = 8;
    localparam int DEPTH = 4;
    localparam int QDEPTH = 4;
    localparam int NRULE = 8;
    localparam int ACT_MAX = 39;

    // One command word as driven on s_*
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] arg;
        logic [7:0] evt;
        logic [7:0] hmask;
        logic [7:0] gmask;
    } cmd_t;

    // One action word as seen on m_*
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] st;
        logic [7:0] evt;
        logic [2:0] sts;
        logic       last;
    } act_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    hierarchical_state_transition_engine_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // Shadow configuration and machine state
    logic [31:0] sh_parent;
    logic [3:0]  sh_nstates;
    logic [3:0]  sh_nrules;
    logic [63:0] sh_rule_evt;
    logic [31:0] sh_rule_from;
    logic [23:0] sh_rule_to;
    logic [2:0]  sh_cur;
    logic        sh_started;
    logic        sh_enabled;
    logic [10:0] sh_pend[$];

    act_t  expected_actions[$];
    cmd_t  pending_cmds[$];
    act_t  run_buf[$];
    logic [2:0] run_sts;

    int mismatches = 0;
    int results_seen = 0;
    bit stim_done = 0;

    function automatic int live_states();
        return (sh_nstates > NST) ? NST : int'(sh_nstates);
    endfunction

    function automatic void add_action(logic [2:0] k, logic [2:0] s, logic [7:0] e);
        act_t a;
        if (run_buf.size() >= ACT_MAX) return;
        a.kind = k; a.st = s; a.evt = e; a.sts = STS_OK; a.last = 1'b0;
        run_buf.push_back(a);
    endfunction

    function automatic void flag(logic [2:0] code);
        if (run_sts == STS_OK) run_sts = code;
    endfunction

    // Ancestor list, leaf first, cut at DEPTH
    function automatic int ancestors(logic [2:0] s, ref logic [2:0] lst[DEPTH]);
        int n = 0;
        logic [3:0] p;
        while (n < DEPTH) begin
            lst[n] = s;
            n++;
            p = sh_parent[4*s +: 4];
            if (int'(p) >= live_states()) break;
            s = p[2:0];
        end
        return n;
    endfunction

    function automatic void move_to(logic [2:0] tgt, logic [7:0] e);
        logic [2:0] a[DEPTH];
        logic [2:0] b[DEPTH];
        int la, lb, k;
        if (int'(tgt) >= live_states()) begin flag(STS_BAD_STATE); return; end
        if (tgt == sh_cur) return;
        la = ancestors(sh_cur, a);
        lb = ancestors(tgt, b);
        k = 0;
        while (k < la && k < lb && a[la-1-k] == b[lb-1-k]) k++;
        if (k == 0) begin flag(STS_NO_ANCESTOR); return; end
        for (int i = 0; i < la - k; i++) add_action(KIND_EXIT, a[i], e);
        for (int i = lb - k; i > 0; i--) add_action(KIND_ENTRY, b[i-1], e);
        sh_cur = tgt;
    endfunction

    function automatic void drain_pending();
        logic [10:0] ent;
        while (sh_pend.size() > 0) begin
            ent = sh_pend.pop_front();
            move_to(ent[10:8], ent[7:0]);
        end
    endfunction

    function automatic void enqueue(logic [2:0] tgt, logic [7:0] e);
        if (int'(tgt) >= live_states()) begin flag(STS_BAD_STATE); return; end
        if (sh_pend.size() >= QDEPTH) begin flag(STS_QUEUE_FULL); return; end
        sh_pend.push_back({tgt, e});
    endfunction

    function automatic bit may_run();
        if (!sh_enabled) begin flag(STS_DISABLED); return 0; end
        if (!sh_started) begin flag(STS_NOT_STARTED); return 0; end
        return 1;
    endfunction

    // Predicts the run of one accepted command and appends it to expected_actions
    function automatic void predict_run(cmd_t c);
        logic [2:0] lst[DEPTH];
        int n, rc;
        act_t fin;
        run_buf.delete();
        run_sts = STS_OK;
        case (c.op)
            OP_START: begin
                if (int'(c.arg) >= live_states()) flag(STS_BAD_STATE);
                else begin
                    sh_enabled = 1'b1;
                    n = ancestors(c.arg, lst);
                    for (int i = n; i > 0; i--) add_action(KIND_ENTRY, lst[i-1], c.evt);
                    sh_cur = c.arg;
                    sh_started = 1'b1;
                end
            end
            OP_EVENT: begin
                if (may_run()) begin
                    n = ancestors(sh_cur, lst);
                    for (int i = 0; i < n; i++) begin
                        add_action(KIND_HANDLER, lst[i], c.evt);
                        if (c.hmask[lst[i]]) break;
                    end
                    rc = (sh_nrules > NRULE) ? NRULE : int'(sh_nrules);
                    for (int r = 0; r < rc; r++) begin
                        if (sh_rule_evt[8*r +: 8] != c.evt) continue;
                        if (sh_rule_from[4*r +: 4] != ANY_STATE &&
                            sh_rule_from[4*r +: 4] != {1'b0, sh_cur}) continue;
                        if (!c.gmask[r]) continue;
                        enqueue(sh_rule_to[3*r +: 3], c.evt);
                        break;
                    end
                    drain_pending();
                end
            end
            OP_REQUEST: begin
                if (!sh_enabled) flag(STS_DISABLED);
                else if (int'(c.arg) >= live_states()) flag(STS_BAD_STATE);
                else if (!sh_started) flag(STS_NOT_STARTED);
                else enqueue(c.arg, c.evt);
            end
            OP_TICK: begin
                if (may_run()) begin
                    drain_pending();
                    add_action(KIND_CONT, sh_cur, 8'd0);
                end
            end
            OP_ENABLE: sh_enabled = c.arg[0];
            default: ;
        endcase
        foreach (run_buf[i]) expected_actions.push_back(run_buf[i]);
        fin = '0;
        fin.kind = KIND_STATUS;
        fin.sts = run_sts;
        fin.last = 1'b1;
        expected_actions.push_back(fin);
    endfunction

    // Driver: bursts with random gaps; hold-off flag lets the bench pause it
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_off = 0;
    cmd_t cur_cmd;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_run(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !hold_off) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata <= {8'd0, cur_cmd.gmask, cur_cmd.hmask, cur_cmd.evt,
                                cur_cmd.arg};
                    s_tuser <= cur_cmd.op;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: a rotating mask with occasional free-running spells
    logic [15:0] stall_pat;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_pat <= 16'hB5E3;
        end else begin
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
            if ($urandom_range(0, 63) == 0) stall_pat <= $urandom;
            if ($urandom_range(0, 99) < 3) stall_pat <= 16'hFFFF;
            m_tready <= stall_pat[0];
        end
    end

    // Monitor: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin
        act_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.st = m_tdata[2:0];
            got.evt = m_tdata[10:3];
            got.sts = m_tdata[13:11];
            got.last = m_tlast;
            results_seen++;
            if (expected_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d state %0d evt %0h sts %0d last %0b",
                             got.kind, got.st, got.evt, got.sts, got.last);
            end else begin
                want = expected_actions.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at word %0d: exp k%0d s%0d e%0h st%0d l%0b, %s",
                                 results_seen, want.kind, want.st, want.evt, want.sts,
                                 want.last,
                                 $sformatf("got k%0d s%0d e%0h st%0d l%0b", got.kind,
                                           got.st, got.evt, got.sts, got.last));
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PARENT:    sh_parent = val[31:0];
            REG_STATE_CNT: sh_nstates = val[3:0];
            REG_RULE_CNT:  sh_nrules = val[3:0];
            REG_RULE_EVT:  sh_rule_evt = val;
            REG_RULE_FROM: sh_rule_from = val[31:0];
            REG_RULE_TO:   sh_rule_to = val[23:0];
            default: ;
        endcase
    endtask

    // Waits until all queued commands are taken and every run has come back
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_actions.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic void queue_cmd(logic [2:0] op, logic [2:0] arg, logic [7:0] e,
                                      logic [7:0] hm, logic [7:0] gm);
        cmd_t c;
        c.op = op; c.arg = arg; c.evt = e; c.hmask = hm; c.gmask = gm;
        pending_cmds.push_back(c);
    endfunction

    // Rule tables with events drawn from a small set so events match often
    task automatic load_rules(int nrules, bit wide_from);
        logic [63:0] ev;
        logic [31:0] fr;
        logic [23:0] to;
        for (int r = 0; r < 8; r++) begin
            ev[8*r +: 8] = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) fr[4*r +: 4] = ANY_STATE;
            else fr[4*r +: 4] = wide_from ? 4'($urandom) : 4'($urandom_range(0, 7));
            to[3*r +: 3] = 3'($urandom);
        end
        write_reg(REG_RULE_CNT, 64'(nrules));
        write_reg(REG_RULE_EVT, ev);
        write_reg(REG_RULE_FROM, {32'($urandom), fr});
        write_reg(REG_RULE_TO, {$urandom, 8'($urandom), to});
    endtask

    // Random tree: mostly shallow forest, sometimes chains or cycles
    task automatic load_tree(int nst);
        logic [31:0] pt;
        for (int s = 0; s < 8; s++) begin
            case ($urandom_range(0, 5))
                0: pt[4*s +: 4] = 4'd8;
                1: pt[4*s +: 4] = 4'($urandom);
                default: pt[4*s +: 4] = (s == 0) ? 4'd8 : 4'($urandom_range(0, s - 1));
            endcase
        end
        write_reg(REG_PARENT, 64'(pt));
        write_reg(REG_STATE_CNT, 64'(nst));
    endtask

    task automatic random_phase(int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0, 1:             op = OP_START;
                2, 3, 4, 5, 6, 7, 8: op = OP_EVENT;
                9, 10, 11, 12:    op = OP_REQUEST;
                13, 14, 15:       op = OP_TICK;
                16:               op = OP_ENABLE;
                17:               op = 3'($urandom_range(5, 7));
                default:          op = OP_EVENT;
            endcase
            queue_cmd(op, (op == OP_ENABLE && $urandom_range(0, 3) != 0) ? 3'd1
                          : 3'($urandom),
                      $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                      8'($urandom), $urandom_range(0, 2) == 0 ? 8'hFF : 8'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tdata = '0;
        s_tuser = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        sh_parent = 32'h8888_8888;
        sh_nstates = 4'd1;
        sh_nrules = '0;
        sh_rule_evt = '0;
        sh_rule_from = '0;
        sh_rule_to = '0;
        sh_cur = '0;
        sh_started = 1'b0;
        sh_enabled = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: commands before start, on reset configuration
        queue_cmd(OP_EVENT, 3'd0, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_ENABLE, 3'd1, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_REQUEST, 3'd0, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(OP_START, 3'd7, 8'hFF, 8'h00, 8'h00);
        queue_cmd(3'd5, 3'd7, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // Directed: deep tree 0 <- 1 <- 2 <- 3 <- 4 <- 5, 6 a root, 7 under 6
        write_reg(REG_PARENT, 64'h6843_2108);
        write_reg(REG_STATE_CNT, 64'd8);
        write_reg(REG_RULE_EVT, 64'hFF00_0101_0202_0303);
        write_reg(REG_RULE_FROM, 64'h8888_0123);
        write_reg(REG_RULE_TO, 64'h00FF_FFFF);
        write_reg(REG_RULE_CNT, 64'd8);
        queue_cmd(OP_START, 3'd5, 8'h11, 8'h00, 8'h00);
        queue_cmd(OP_EVENT, 3'd0, 8'h42, 8'h00, 8'hFF);
        queue_cmd(OP_EVENT, 3'd0, 8'h42, 8'h20, 8'hFF);
        for (int i = 0; i < 5; i++) queue_cmd(OP_REQUEST, 3'(i), 8'(8'hA0 + i), 8'h00, 8'h00);
        queue_cmd(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_REQUEST, 3'd6, 8'h55, 8'h00, 8'h00);
        queue_cmd(OP_REQUEST, 3'd5, 8'h56, 8'h00, 8'h00);
        queue_cmd(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_EVENT, 3'd0, 8'hFF, 8'hFF, 8'h80);
        queue_cmd(OP_EVENT, 3'd0, 8'h03, 8'h00, 8'h01);
        queue_cmd(OP_ENABLE, 3'd0, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_EVENT, 3'd0, 8'h03, 8'h00, 8'hFF);
        queue_cmd(OP_REQUEST, 3'd1, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_START, 3'd0, 8'h00, 8'h00, 8'h00);
        wait_idle();
        // Shrink the tree with targets still queued: skipped as bad state
        queue_cmd(OP_REQUEST, 3'd7, 8'h01, 8'h00, 8'h00);
        queue_cmd(OP_REQUEST, 3'd3, 8'h02, 8'h00, 8'h00);
        wait_idle();
        write_reg(REG_STATE_CNT, 64'd2);
        queue_cmd(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(REG_STATE_CNT, 64'd0);
        queue_cmd(OP_START, 3'd0, 8'h00, 8'h00, 8'h00);
        queue_cmd(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(REG_STATE_CNT, 64'd15);

        // Random phases across tree and rule settings
        for (int ph = 0; ph < 9; ph++) begin
            load_tree(ph == 0 ? 8 : (ph == 1 ? 1 : $urandom_range(2, 15)));
            load_rules(ph == 2 ? 0 : (ph == 3 ? 15 : $urandom_range(1, 8)), ph > 4);
            queue_cmd(OP_START, 3'($urandom), 8'($urandom), 8'h00, 8'h00);
            random_phase(48);
            // Sender holds off once until the engine has drained everything
            if (ph == 4) begin
                while (pending_cmds.size() > 24) @(posedge aclk);
                hold_off = 1;
                while (s_tvalid || expected_actions.size() > 0) @(posedge aclk);
                hold_off = 0;
            end
            wait_idle();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        @(posedge aclk);
        if (mismatches == 0 && expected_actions.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
